FILE: src/stepper_ramp_interval_generator_assert.svh
// Assertion macros for the stepper ramp interval generator.
// Expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef STEPPER_RAMP_INTERVAL_GENERATOR_ASSERT_SVH
`define STEPPER_RAMP_INTERVAL_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRIG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRIG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/srig_pkg.sv
// Shared types and codes of the stepper ramp interval generator.
// No dependencies.
package srig_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_REL  = 2'd1,
    OP_ABS  = 2'd2,
    OP_ZERO = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY,
    ST_FIN
  } state_t;

  localparam logic [1:0] CFG_START_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_MIN_INTERVAL   = 2'd1;
  localparam logic [1:0] CFG_DIR_INVERT     = 2'd2;

  localparam logic [15:0] START_INTERVAL_RST = 16'd5000;
  localparam logic [15:0] MIN_INTERVAL_RST   = 16'd100;

endpackage

FILE: src/stepper_ramp_interval_generator.sv
// Stepper ramp interval generator: trapezoidal profile, interval update per tick.
// Move and zero commands wait in ST_FIN until the result register is free.
// A tick that recomputes the interval runs a shared restoring divider,
// one quotient bit per cycle, then ST_APPLY updates the interval.
// Accepts one item at a time; the result register frees the input side.
// Synchronous active-low reset: config to defaults, all motion state zero.
module stepper_ramp_interval_generator
  import srig_pkg::*;
#(
  parameter int FRAC_BITS   = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] steps (signed)
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] step_pulse, [1] dir_pin, [17:2] next_interval, [49:18] position (signed),
  // [50] move_done, [55:51] zero
  output logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int IW   = 16 + FRAC_BITS;
  localparam int DVW  = COUNT_WIDTH + 2;
  localparam int CNTW = $clog2(IW + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [31:0] COUNT_MAX32 = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [IW-1:0] IV_MAX = {IW{1'b1}};
  localparam logic [CNTW-1:0] CNT_LOAD = CNTW'(IW);

  // configuration
  logic [15:0] start_interval_r, min_interval_r;
  logic        dir_invert_r;

  // motion state
  state_t                 state_r, state_nxt;
  logic [31:0]            position_r, position_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  logic [COUNT_WIDTH-1:0] taken_r, taken_nxt;
  logic [COUNT_WIDTH-1:0] ramp_up_r, ramp_up_nxt;
  logic [COUNT_WIDTH-1:0] index_r, index_nxt;
  logic [IW-1:0]          interval_r, interval_nxt;
  logic                   sign_neg_r, sign_neg_nxt;
  logic                   dir_r, dir_nxt;
  logic                   done_r, done_nxt;
  logic                   pulse_r, pulse_nxt;
  logic                   accel_r, accel_nxt;

  // divider
  logic [DVW-1:0]  div_r, div_nxt;
  logic [DVW-1:0]  rem_r, rem_nxt;
  logic [IW:0]     dvd_r, dvd_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [55:0] out_data_r, out_data_nxt;

  logic                   in_xfer;
  op_t                    op;
  logic [31:0]            mag_src, mag, diff;
  logic                   neg;
  logic [COUNT_WIDTH-1:0] mag_sat, steps_inc, idx_inc, idx_dec;
  logic [DVW+1:0]         trial;
  logic [IW-1:0]          quot, d_sub, minf;
  logic [IW:0]            d_sum;
  logic                   load_out;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign op         = op_t'(in_tuser);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign diff      = in_tdata - position_r;
  assign steps_inc = taken_r + 1'b1;
  assign idx_inc   = (index_r != COUNT_MAX) ? index_r + 1'b1 : index_r;
  assign idx_dec   = index_r - 1'b1;
  assign trial     = {1'b0, rem_r, dvd_r[IW]} - {2'b00, div_r};
  assign quot      = dvd_r[IW-1:0];
  assign d_sub     = interval_r - quot;
  assign d_sum     = {1'b0, interval_r} + {1'b0, quot};
  assign minf      = IW'(min_interval_r) << FRAC_BITS;
  assign load_out  = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    mag_src = (op == OP_ABS) ? diff : in_tdata;
    mag     = mag_src[31] ? (32'd0 - mag_src) : mag_src;
    mag_sat = (mag > COUNT_MAX32) ? COUNT_MAX : mag[COUNT_WIDTH-1:0];
    neg     = mag_src[31];
  end

  always_comb begin
    state_nxt     = state_r;
    position_nxt  = position_r;
    total_nxt     = total_r;
    taken_nxt     = taken_r;
    ramp_up_nxt   = ramp_up_r;
    index_nxt     = index_r;
    interval_nxt  = interval_r;
    sign_neg_nxt  = sign_neg_r;
    dir_nxt       = dir_r;
    done_nxt      = done_r;
    pulse_nxt     = pulse_r;
    accel_nxt     = accel_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          pulse_nxt = 1'b0;
          state_nxt = ST_FIN;
          case (op)
            OP_TICK: begin
              if (taken_r < total_r) begin
                pulse_nxt    = 1'b1;
                taken_nxt    = steps_inc;
                position_nxt = sign_neg_r ? position_r - 32'd1 : position_r + 32'd1;
                if (steps_inc >= total_r) begin
                  done_nxt = 1'b1;
                end
                // start the interval division for this step
                rem_nxt = '0;
                dvd_nxt = {interval_r, 1'b0};
                cnt_nxt = CNT_LOAD;
                if (ramp_up_r == '0) begin
                  index_nxt = idx_inc;
                  div_nxt   = {idx_inc, 2'b01};
                  accel_nxt = 1'b1;
                  state_nxt = ST_DIV;
                end else if ((steps_inc >= total_r - ramp_up_r) && (index_r != '0)) begin
                  index_nxt = idx_dec;
                  div_nxt   = {idx_dec, 2'b11};
                  accel_nxt = 1'b0;
                  state_nxt = ST_DIV;
                end
              end
            end
            OP_REL, OP_ABS: begin
              if (mag_src != 32'd0) begin
                if (op == OP_REL && dir_invert_r) begin
                  dir_nxt      = !neg;
                  sign_neg_nxt = !neg;
                end else begin
                  dir_nxt      = neg;
                  sign_neg_nxt = neg;
                end
                total_nxt    = mag_sat;
                interval_nxt = IW'(start_interval_r) << FRAC_BITS;
                taken_nxt    = '0;
                index_nxt    = '0;
                ramp_up_nxt  = '0;
                done_nxt     = 1'b0;
              end
            end
            OP_ZERO: begin
              position_nxt = '0;
            end
            default: begin
              position_nxt = position_r;
            end
          endcase
        end
      end
      ST_DIV: begin
        // one restoring step: shift in a dividend bit, subtract if it fits
        if (!trial[DVW+1]) begin
          rem_nxt = trial[DVW-1:0];
        end else begin
          rem_nxt = {rem_r[DVW-2:0], dvd_r[IW]};
        end
        dvd_nxt = {dvd_r[IW-1:0], !trial[DVW+1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (accel_r) begin
          interval_nxt = d_sub;
          if (d_sub <= minf) begin
            interval_nxt = minf;
            ramp_up_nxt  = taken_r;
          end
          if (taken_r >= (total_r >> 1)) begin
            ramp_up_nxt = taken_r;
          end
        end else begin
          interval_nxt = d_sum[IW] ? IV_MAX : d_sum[IW-1:0];
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the result register is free
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, done_r, position_r, 16'(interval_r >> FRAC_BITS),
                           dir_r, pulse_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_interval_r <= START_INTERVAL_RST;
      min_interval_r   <= MIN_INTERVAL_RST;
      dir_invert_r     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_INTERVAL: start_interval_r <= cfg_wdata;
        CFG_MIN_INTERVAL:   min_interval_r   <= cfg_wdata;
        CFG_DIR_INVERT:     dir_invert_r     <= cfg_wdata[0];
        default:            dir_invert_r     <= dir_invert_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      position_r  <= '0;
      total_r     <= '0;
      taken_r     <= '0;
      ramp_up_r   <= '0;
      index_r     <= '0;
      interval_r  <= '0;
      sign_neg_r  <= 1'b0;
      dir_r       <= 1'b0;
      done_r      <= 1'b0;
      pulse_r     <= 1'b0;
      accel_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      position_r  <= position_nxt;
      total_r     <= total_nxt;
      taken_r     <= taken_nxt;
      ramp_up_r   <= ramp_up_nxt;
      index_r     <= index_nxt;
      interval_r  <= interval_nxt;
      sign_neg_r  <= sign_neg_nxt;
      dir_r       <= dir_nxt;
      done_r      <= done_nxt;
      pulse_r     <= pulse_nxt;
      accel_r     <= accel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

`include "stepper_ramp_interval_generator_assert.svh"

  `SRIG_ASSERT_IMPL(a_taken_bounded, 1'b1, taken_r <= total_r, "steps taken exceed total")
  `SRIG_ASSERT_IMPL(a_done_complete, done_r, taken_r == total_r, "done before last step")
  `SRIG_ASSERT_IMPL(a_ramp_bounded, 1'b1, ramp_up_r <= taken_r, "ramp length beyond steps")
  `SRIG_ASSERT_NEXT(a_div_odd, in_xfer && (state_nxt == ST_DIV), div_r[0],
                    "divisor not odd at division start")

endmodule

FILE: tb/sv/tb_stepper_ramp_interval_generator.sv
// Self-checking testbench for stepper_ramp_interval_generator: directed and random
// commands, predicted by an in-bench ramp model and checked result by result.
// Depends on srig_pkg and the generator RTL only.
module tb_stepper_ramp_interval_generator import srig_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAC_BITS    = 8;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          RANDOM_ITEMS = 1300;
  localparam int          MAX_PRINTS   = 50;
  localparam logic [63:0] INTERVAL_MAX = 64'hFF_FFFF;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_EVERY_THIRD} rx_mode_t;

  typedef struct packed {
    logic        pulse;
    logic        dir;
    logic [15:0] interval;
    logic [31:0] position;
    logic        done;
  } step_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] steps (signed)
  logic [1:0]  in_tuser;   // [1:0] operation
  logic        out_tvalid;
  logic        out_tready;
  // [0] step_pulse, [1] dir_pin, [17:2] next_interval, [49:18] position,
  // [50] move_done, [55:51] zero
  logic [55:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // predictor configuration and motion state
  logic [15:0] start_iv;
  logic [15:0] min_iv;
  logic        invert_dir;
  logic [31:0] pos_cnt;
  logic [31:0] move_total;
  logic [31:0] moved;
  logic [31:0] cruise_at;
  logic [31:0] accel_idx;
  logic [23:0] interval_fx;
  logic        count_down;
  logic        dir_out;
  logic        move_finished;

  step_result_t expected_steps[$];
  int errors;
  int results_seen;
  int items_sent;
  int cycle_count;
  int burst_left;
  int hold_left;
  int rx_left;
  int rx_phase;
  rx_mode_t rx_mode;
  logic hold_req;

  stepper_ramp_interval_generator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_ramp_model();
    start_iv      = START_INTERVAL_RST;
    min_iv        = MIN_INTERVAL_RST;
    invert_dir    = 1'b1;
    pos_cnt       = '0;
    move_total    = '0;
    moved         = '0;
    cruise_at     = '0;
    accel_idx     = '0;
    interval_fx   = '0;
    count_down    = 1'b0;
    dir_out       = 1'b0;
    move_finished = 1'b0;
  endfunction

  function automatic void start_move(logic negative, logic [31:0] distance);
    logic [31:0] mag;
    mag           = distance[31] ? (32'd0 - distance) : distance;
    dir_out       = negative;
    count_down    = negative;
    move_total    = mag;
    interval_fx   = {start_iv, {FRAC_BITS{1'b0}}};
    moved         = '0;
    accel_idx     = '0;
    cruise_at     = '0;
    move_finished = 1'b0;
  endfunction

  // Apply one command to the ramp model and return the result it produces.
  function automatic step_result_t advance_ramp_model(op_t op, logic [31:0] steps);
    logic [63:0]  iv;
    logic [63:0]  min_fx;
    logic [63:0]  n4;
    logic [31:0]  diff;
    logic         pulse;
    step_result_t res;
    pulse = 1'b0;
    case (op)
      OP_TICK: begin
        if (moved < move_total) begin
          pulse = 1'b1;
          iv    = 64'(interval_fx);
          moved++;
          pos_cnt += count_down ? 32'hFFFF_FFFF : 32'd1;
          if (moved >= move_total) move_finished = 1'b1;
          if (cruise_at == 0) begin
            min_fx = 64'(min_iv) << FRAC_BITS;
            if (accel_idx != 32'hFFFF_FFFF) accel_idx++;
            iv = iv - (2 * iv) / (4 * 64'(accel_idx) + 1);
            if (iv <= min_fx) begin
              iv        = min_fx;
              cruise_at = moved;
            end
            if (moved >= move_total / 2) cruise_at = moved;
          end else if (moved >= move_total - cruise_at) begin
            // no change once the index has run down to zero
            if (accel_idx >= 1) begin
              n4 = 4 * 64'(accel_idx);
              iv = (iv * (n4 + 1)) / (n4 - 1);
              if (iv > INTERVAL_MAX) iv = INTERVAL_MAX;
              accel_idx--;
            end
          end
          interval_fx = iv[23:0];
        end
      end
      OP_REL: begin
        if (steps != 0) begin
          start_move(invert_dir ? !steps[31] : steps[31], steps);
        end
      end
      OP_ABS: begin
        diff = steps - pos_cnt;
        if (diff != 0) start_move(diff[31], diff);
      end
      default: pos_cnt = '0;
    endcase
    res.pulse    = pulse;
    res.dir      = dir_out;
    res.interval = interval_fx[FRAC_BITS +: 16];
    res.position = pos_cnt;
    res.done     = move_finished;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < MAX_PRINTS) begin
      $display("mismatch in %s at result %0d: got %h, expected %h", what, results_seen, got,
               want);
    end
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    step_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_steps.size() == 0) begin
        report_mismatch("unexpected transfer", 32'(out_tdata), '0);
      end else begin
        want = expected_steps.pop_front();
        if (out_tdata[0] !== want.pulse) begin
          report_mismatch("step_pulse", 32'(out_tdata[0]), 32'(want.pulse));
        end
        if (out_tdata[1] !== want.dir) begin
          report_mismatch("dir_pin", 32'(out_tdata[1]), 32'(want.dir));
        end
        if (out_tdata[17:2] !== want.interval) begin
          report_mismatch("next_interval", 32'(out_tdata[17:2]), 32'(want.interval));
        end
        if (out_tdata[49:18] !== want.position) begin
          report_mismatch("position", out_tdata[49:18], want.position);
        end
        if (out_tdata[50] !== want.done) begin
          report_mismatch("move_done", 32'(out_tdata[50]), 32'(want.done));
        end
        if (out_tdata[55:51] !== 5'd0) begin
          report_mismatch("pad bits", 32'(out_tdata[55:51]), '0);
        end
      end
      results_seen++;
    end
  end

  // receiver: stall pattern in random stretches, long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 80);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_tready <= ($urandom_range(0, 9) != 0);
        default:   out_tready <= (rx_phase % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_stepper_ramp_interval_generator failed");
      $finish;
    end
  end

  // Offer one command; gaps between bursts drop tvalid first.
  task automatic send_item(op_t op, logic [31:0] steps);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= steps;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    expected_steps.push_back(advance_ramp_model(op, steps));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_steps.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_START_INTERVAL: start_iv = value;
      CFG_MIN_INTERVAL:   min_iv = value;
      CFG_DIR_INVERT:     invert_dir = value[0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_interval();
    case ($urandom_range(0, 5))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 40));
      3:       return 16'($urandom_range(40, 600));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic tick_n(int n);
    repeat (n) send_item(OP_TICK, $urandom());
  endtask

  // an idle tick, zeroing and zero-length moves straight out of reset
  task automatic test_commands_at_reset();
    send_item(OP_TICK, 32'h0);
    send_item(OP_ZERO, 32'hFFFF_FFFF);
    send_item(OP_REL, 32'h0);
    send_item(OP_ABS, 32'h0);
  endtask

  // both settings of the direction inversion, full short profile, idle tick after done
  task automatic test_relative_direction();
    send_item(OP_REL, 32'd3);
    tick_n(4);
    wait_drained();
    write_reg(CFG_DIR_INVERT, 16'd0);
    send_item(OP_REL, 32'hFFFF_FFFE);
    tick_n(2);
    send_item(OP_REL, 32'h7FFF_FFFF);
    tick_n(1);
  endtask

  // absolute distances that wrap, most negative relative count
  task automatic test_absolute_wrap();
    send_item(OP_ABS, 32'h8000_0000);
    tick_n(1);
    send_item(OP_ABS, 32'h7FFF_FFFF);
    tick_n(1);
    send_item(OP_REL, 32'h8000_0000);
    tick_n(1);
  endtask

  // slowest settings: deceleration clips the interval at full scale
  task automatic test_interval_saturation();
    wait_drained();
    write_reg(CFG_START_INTERVAL, 16'hFFFF);
    write_reg(CFG_MIN_INTERVAL, 16'hFFFF);
    write_reg(CFG_DIR_INVERT, 16'd1);
    send_item(OP_REL, 32'd3);
    tick_n(3);
  endtask

  // hold the result side while the sender keeps offering
  task automatic test_backpressure();
    wait_drained();
    write_reg(CFG_START_INTERVAL, 16'd400);
    write_reg(CFG_MIN_INTERVAL, 16'd20);
    hold_req = 1'b1;
    send_item(OP_REL, 32'd25);
    tick_n(30);
  endtask

  task automatic run_random_move();
    int          kind;
    int          ticks;
    logic [31:0] cnt;
    kind = $urandom_range(0, 15);
    if (kind < 9) begin
      cnt = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(1, 60));
      if ($urandom_range(0, 1) == 1) cnt = 32'd0 - cnt;
      send_item(OP_REL, cnt);
    end else if (kind < 12) begin
      if ($urandom_range(0, 4) == 0) cnt = $urandom();
      else cnt = pos_cnt + 32'($urandom_range(0, 80)) - 32'd40;
      send_item(OP_ABS, cnt);
    end else if (kind < 14) begin
      send_item(op_t'($urandom_range(0, 3)), $urandom());
    end else begin
      send_item(OP_ZERO, $urandom());
    end
    ticks = (move_total - moved > 32'd80) ? 80 : int'(move_total - moved);
    // cut some moves short so the next command lands mid-ramp
    if ($urandom_range(0, 5) == 0) ticks = $urandom_range(0, ticks);
    ticks += $urandom_range(0, 3);
    tick_n(ticks);
  endtask

  task automatic test_random_moves();
    int stop_at;
    int next_cfg;
    stop_at  = items_sent + RANDOM_ITEMS;
    next_cfg = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= next_cfg) begin
        wait_drained();
        write_reg(CFG_START_INTERVAL, pick_interval());
        write_reg(CFG_MIN_INTERVAL, pick_interval());
        write_reg(CFG_DIR_INVERT, 16'($urandom_range(0, 1)));
        next_cfg = items_sent + $urandom_range(60, 150);
      end
      run_random_move();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_TICK;
    out_tready   = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_START_INTERVAL;
    cfg_wdata    = '0;
    hold_req     = 1'b0;
    errors       = 0;
    results_seen = 0;
    items_sent   = 0;
    cycle_count  = 0;
    burst_left   = 0;
    hold_left    = 0;
    rx_left      = 0;
    rx_phase     = 0;
    rx_mode      = RX_OPEN;
    reset_ramp_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_commands_at_reset();
    test_relative_direction();
    test_absolute_wrap();
    test_interval_saturation();
    test_backpressure();
    test_random_moves();

    wait_drained();
    if (expected_steps.size() != 0) begin
      report_mismatch("results left outstanding", 32'(expected_steps.size()), '0);
    end
    if (errors == 0) begin
      $display("tb_stepper_ramp_interval_generator passed");
    end else begin
      $display("tb_stepper_ramp_interval_generator failed");
    end
    $finish;
  end

endmodule

FILE: stepper_ramp_interval_generator.f
+incdir+src
src/srig_pkg.sv
src/stepper_ramp_interval_generator.sv
tb/sv/tb_stepper_ramp_interval_generator.sv
